### rtl/core/tbgs_pkg.sv
// ----------------------------------------------------------------------------
// tbgs_pkg: shared types, codes and fixed-point helpers
// Q32.32 word types, datapath operation codes, controller states and the
// saturating arithmetic used by the two-body gravity stepper.
// ----------------------------------------------------------------------------
package tbgs_pkg;

    localparam int WORD_W  = 64;
    localparam int PROD_W  = 128;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GM_FIRST     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GM_SECOND    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_DIST = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 8'd3;

    localparam logic [63:0] GM_FIRST_RST     = 64'd3568736787221394;
    localparam logic [63:0] GM_SECOND_RST    = 64'd187828;
    localparam logic [62:0] CONTACT_DIST_RST = 63'd8589934592;
    localparam logic [62:0] TIME_STEP_RST    = 63'd4294967296;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic signed [63:0] MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MINV = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] G_CAP = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic               cmd;
        logic signed [63:0] load_x_first;
        logic signed [63:0] load_y_first;
        logic signed [63:0] load_x_second;
        logic signed [63:0] load_y_second;
        logic signed [63:0] load_vx_first;
        logic signed [63:0] load_vy_first;
        logic signed [63:0] load_vx_second;
        logic signed [63:0] load_vy_second;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] pos_x_first;
        logic signed [63:0] pos_y_first;
        logic signed [63:0] pos_x_second;
        logic signed [63:0] pos_y_second;
        logic               collided;
    } out_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DT2,
        OP_WB_DT2,
        OP_MUL_AV,
        OP_WB_V,
        OP_MUL_VV,
        OP_WB_T,
        OP_MUL_AH,
        OP_WB_P,
        OP_SEP,
        OP_MUL_SX,
        OP_WB_SX,
        OP_MUL_SY,
        OP_WB_SY,
        OP_MUL_CC,
        OP_WB_CC,
        OP_ZERO_ACC,
        OP_SQRT,
        OP_WB_R,
        OP_DIV_G1,
        OP_WB_G1,
        OP_DIV_G2,
        OP_WB_G2,
        OP_DIV_U,
        OP_WB_U,
        OP_MUL_A1,
        OP_WB_A1,
        OP_MUL_A2,
        OP_WB_A2,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT2_M, ST_DT2_W,
        ST_AV_M, ST_AV_W,
        ST_VV_M, ST_VV_W,
        ST_AH_M, ST_AH_W,
        ST_SEP,
        ST_SX_M, ST_SX_W,
        ST_SY_M, ST_SY_W,
        ST_CC_M, ST_CC_W,
        ST_CHK,
        ST_SQ_S, ST_SQ_W,
        ST_G1_S, ST_G1_W,
        ST_G2_S, ST_G2_W,
        ST_U_S, ST_U_W,
        ST_A1_M, ST_A1_W,
        ST_A2_M, ST_A2_W,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic s_zero;
        logic halted;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? MINV : MAXV;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? MINV : MAXV;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag_of(logic signed [63:0] a);
        logic [63:0] u;
        u = a;
        return a[63] ? (~u + 64'd1) : u;
    endfunction

    function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
        if (!neg)
            return m[63] ? MAXV : m;
        return (m > G_CAP) ? MINV : (~m + 64'd1);
    endfunction

    // round half away from zero, shift by 32 or 33, saturate
    function automatic logic signed [63:0] qround(logic [127:0] p, logic half,
                                                  logic neg);
        logic [128:0] r;
        logic [63:0]  m;
        logic         ovf;
        if (half)
        begin
            r   = {1'b0, p} + (129'd1 << 32);
            ovf = |r[128:97];
            m   = r[96:33];
        end
        else
        begin
            r   = {1'b0, p} + (129'd1 << 31);
            ovf = |r[128:96];
            m   = r[95:32];
        end
        return from_mag(neg, ovf ? '1 : m);
    endfunction

    function automatic logic [63:0] amag(logic [127:0] p);
        logic [127:0] t;
        t = p + (128'd1 << 61);
        return t[125:62];
    endfunction

endpackage

### rtl/core/tbgs_mul.sv
// ----------------------------------------------------------------------------
// tbgs_mul: sequential 64x64 unsigned multiplier
// One 32x32 partial product per cycle, registered, then accumulated.
// ----------------------------------------------------------------------------
module tbgs_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         busy,
    output logic [127:0] prod
);
    import tbgs_pkg::*;

    logic         busy_reg;
    logic [2:0]   step_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp_comb;
    logic [127:0] pp_shifted;

    always_comb
    begin
        a_half  = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_comb = 64'(a_half) * 64'(b_half);
        case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 3'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd4)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < 3'd4)
            begin
                pp_reg    <= pp_comb;
                pp_sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (step_reg != 3'd0)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

### rtl/core/tbgs_div.sv
// ----------------------------------------------------------------------------
// tbgs_div: restoring divider, 64-bit saturated quotient
// Dividend is {num_hi, num_lo}; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbgs_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num_hi,
    input  logic [63:0]  num_lo,
    input  logic [127:0] den,
    output logic         busy,
    output logic [63:0]  quo
);
    import tbgs_pkg::*;

    logic         busy_reg;
    logic [5:0]   cnt_reg;
    logic         over_reg;
    logic [127:0] rem_reg;
    logic [63:0]  lo_reg;
    logic [127:0] den_reg;
    logic [63:0]  q_reg;
    logic [128:0] rem_sh;
    logic         fits;

    always_comb
    begin
        rem_sh = {rem_reg, lo_reg[63]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            over_reg <= num_hi >= den;
            rem_reg  <= num_hi;
            lo_reg   <= num_lo;
            den_reg  <= den;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 128'(rem_sh - {1'b0, den_reg}) : rem_sh[127:0];
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quo  = over_reg ? '1 : q_reg;

endmodule

### rtl/core/tbgs_sqrt.sv
// ----------------------------------------------------------------------------
// tbgs_sqrt: digit-by-digit integer square root
// floor(sqrt) of a 128-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module tbgs_sqrt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] radicand,
    output logic         busy,
    output logic [63:0]  root
);
    import tbgs_pkg::*;

    logic         busy_reg;
    logic [5:0]   cnt_reg;
    logic [127:0] rad_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         fits;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[127:126]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[125:0], 2'b00};
            rem_reg  <= fits ? 66'(rem_sh - trial) : rem_sh[65:0];
            root_reg <= {root_reg[62:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### rtl/core/tbgs_ctrl.sv
// ----------------------------------------------------------------------------
// tbgs_ctrl: sequencing state machine
// Issues datapath operations for load and step words and waits on the units.
// ----------------------------------------------------------------------------
module tbgs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    input  tbgs_pkg::dp_status_t status,
    output logic                 in_stall,
    output tbgs_pkg::dp_cmd_t    cmd
);
    import tbgs_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        mode_next  = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                k_next = 2'd0;
                if (in_valid)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        mode_next  = 1'b0;
                        state_next = ST_SEP;
                    end
                    else if (status.halted)
                        state_next = ST_OUT;
                    else
                    begin
                        mode_next  = 1'b1;
                        state_next = ST_DT2_M;
                    end
                end
            end
            ST_DT2_M: state_next = ST_DT2_W;
            ST_DT2_W: if (!status.busy) state_next = ST_AV_M;
            ST_AV_M:  state_next = ST_AV_W;
            ST_AV_W:  if (!status.busy) state_next = ST_VV_M;
            ST_VV_M:  state_next = ST_VV_W;
            ST_VV_W:  if (!status.busy) state_next = ST_AH_M;
            ST_AH_M:  state_next = ST_AH_W;
            ST_AH_W:
            begin
                if (!status.busy)
                begin
                    k_next = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? ST_SEP : ST_AV_M;
                end
            end
            ST_SEP:   state_next = ST_SX_M;
            ST_SX_M:  state_next = ST_SX_W;
            ST_SX_W:  if (!status.busy) state_next = ST_SY_M;
            ST_SY_M:  state_next = ST_SY_W;
            ST_SY_W:  if (!status.busy) state_next = mode_reg ? ST_CC_M : ST_CHK;
            ST_CC_M:  state_next = ST_CC_W;
            ST_CC_W:  if (!status.busy) state_next = ST_CHK;
            ST_CHK:
            begin
                if (status.halted || status.s_zero)
                    state_next = ST_OUT;
                else
                    state_next = ST_SQ_S;
            end
            ST_SQ_S:  state_next = ST_SQ_W;
            ST_SQ_W:  if (!status.busy) state_next = ST_G1_S;
            ST_G1_S:  state_next = ST_G1_W;
            ST_G1_W:  if (!status.busy) state_next = ST_G2_S;
            ST_G2_S:  state_next = ST_G2_W;
            ST_G2_W:  if (!status.busy) state_next = ST_U_S;
            ST_U_S:   state_next = ST_U_W;
            ST_U_W:   if (!status.busy) state_next = ST_A1_M;
            ST_A1_M:  state_next = ST_A1_W;
            ST_A1_W:  if (!status.busy) state_next = ST_A2_M;
            ST_A2_M:  state_next = ST_A2_W;
            ST_A2_W:
            begin
                if (!status.busy)
                begin
                    if (k_reg == 2'd1)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_U_S;
                    end
                end
            end
            ST_OUT:   if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.k    = k_reg;
        in_stall = state_reg != ST_IDLE;
        case (state_reg)
            ST_IDLE:  if (in_valid && in_cmd == CMD_LOAD) cmd.op = OP_LOAD;
            ST_DT2_M: cmd.op = OP_MUL_DT2;
            ST_DT2_W: if (!status.busy) cmd.op = OP_WB_DT2;
            ST_AV_M:  cmd.op = OP_MUL_AV;
            ST_AV_W:  if (!status.busy) cmd.op = OP_WB_V;
            ST_VV_M:  cmd.op = OP_MUL_VV;
            ST_VV_W:  if (!status.busy) cmd.op = OP_WB_T;
            ST_AH_M:  cmd.op = OP_MUL_AH;
            ST_AH_W:  if (!status.busy) cmd.op = OP_WB_P;
            ST_SEP:   cmd.op = OP_SEP;
            ST_SX_M:  cmd.op = OP_MUL_SX;
            ST_SX_W:  if (!status.busy) cmd.op = OP_WB_SX;
            ST_SY_M:  cmd.op = OP_MUL_SY;
            ST_SY_W:  if (!status.busy) cmd.op = OP_WB_SY;
            ST_CC_M:  cmd.op = OP_MUL_CC;
            ST_CC_W:  if (!status.busy) cmd.op = OP_WB_CC;
            ST_CHK:   if (!status.halted && status.s_zero) cmd.op = OP_ZERO_ACC;
            ST_SQ_S:  cmd.op = OP_SQRT;
            ST_SQ_W:  if (!status.busy) cmd.op = OP_WB_R;
            ST_G1_S:  cmd.op = OP_DIV_G1;
            ST_G1_W:  if (!status.busy) cmd.op = OP_WB_G1;
            ST_G2_S:  cmd.op = OP_DIV_G2;
            ST_G2_W:  if (!status.busy) cmd.op = OP_WB_G2;
            ST_U_S:   cmd.op = OP_DIV_U;
            ST_U_W:   if (!status.busy) cmd.op = OP_WB_U;
            ST_A1_M:  cmd.op = OP_MUL_A1;
            ST_A1_W:  if (!status.busy) cmd.op = OP_WB_A1;
            ST_A2_M:  cmd.op = OP_MUL_A2;
            ST_A2_W:  if (!status.busy) cmd.op = OP_WB_A2;
            ST_OUT:   if (status.out_free) cmd.op = OP_OUT;
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/core/tbgs_dpath.sv
// ----------------------------------------------------------------------------
// tbgs_dpath: body state, configuration and arithmetic units
// Executes one operation per command; the units report busy while running.
// ----------------------------------------------------------------------------
module tbgs_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tbgs_pkg::dp_cmd_t                    cmd,
    output tbgs_pkg::dp_status_t                 status,
    input  tbgs_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output tbgs_pkg::out_word_t                  out_word,
    input  logic                                 cfg_valid,
    input  logic [tbgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [63:0]                          cfg_data
);
    import tbgs_pkg::*;

    logic [63:0] gm_first_reg, gm_second_reg;
    logic [62:0] contact_reg, dt_reg;

    logic signed [63:0] pos_reg [4];
    logic signed [63:0] pos_next [4];
    logic signed [63:0] vel_reg [4];
    logic signed [63:0] vel_next [4];
    logic signed [63:0] acc_reg [4];
    logic signed [63:0] acc_next [4];
    logic               halted_reg, halted_next;
    logic               out_valid_reg, out_valid_next;

    logic [63:0]        dt2_reg, dt2_next;
    logic signed [63:0] tmp_reg, tmp_next;
    logic signed [63:0] dx_reg, dx_next;
    logic signed [63:0] dy_reg, dy_next;
    logic [127:0]       s_reg, s_next;
    logic [63:0]        r_reg, r_next;
    logic [63:0]        g1_reg, g1_next;
    logic [63:0]        g2_reg, g2_next;
    logic [63:0]        u_reg, u_next;
    out_word_t          out_reg, out_next;

    logic               mul_start, mul_busy;
    logic [63:0]        mul_a, mul_b;
    logic [127:0]       prod;
    logic               div_start, div_busy;
    logic [127:0]       div_hi, div_den;
    logic [63:0]        div_lo, quo;
    logic               sqrt_busy;
    logic [63:0]        root;
    logic signed [63:0] acc_sel, vel_sel, pos_sel, d_sel;
    logic [63:0]        d_mag;
    logic [1:0]         k_hi;

    tbgs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (prod)
    );

    tbgs_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (div_hi),
        .num_lo (div_lo),
        .den    (div_den),
        .busy   (div_busy),
        .quo    (quo)
    );

    tbgs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_SQRT),
        .radicand (s_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_comb
    begin
        acc_sel = acc_reg[cmd.k];
        vel_sel = vel_reg[cmd.k];
        pos_sel = pos_reg[cmd.k];
        d_sel   = cmd.k[0] ? dy_reg : dx_reg;
        d_mag   = mag_of(d_sel);
        k_hi    = {1'b1, cmd.k[0]};

        mul_start = cmd.op inside {OP_MUL_DT2, OP_MUL_AV, OP_MUL_VV, OP_MUL_AH,
                                   OP_MUL_SX, OP_MUL_SY, OP_MUL_CC,
                                   OP_MUL_A1, OP_MUL_A2};
        case (cmd.op)
            OP_MUL_AV:
            begin
                mul_a = mag_of(acc_sel);
                mul_b = {1'b0, dt_reg};
            end
            OP_MUL_VV:
            begin
                mul_a = mag_of(vel_sel);
                mul_b = {1'b0, dt_reg};
            end
            OP_MUL_AH:
            begin
                mul_a = mag_of(acc_sel);
                mul_b = dt2_reg;
            end
            OP_MUL_SX:
            begin
                mul_a = mag_of(dx_reg);
                mul_b = mag_of(dx_reg);
            end
            OP_MUL_SY:
            begin
                mul_a = mag_of(dy_reg);
                mul_b = mag_of(dy_reg);
            end
            OP_MUL_CC:
            begin
                mul_a = {1'b0, contact_reg};
                mul_b = {1'b0, contact_reg};
            end
            OP_MUL_A1:
            begin
                mul_a = g1_reg;
                mul_b = u_reg;
            end
            OP_MUL_A2:
            begin
                mul_a = g2_reg;
                mul_b = u_reg;
            end
            default:
            begin
                mul_a = {1'b0, dt_reg};
                mul_b = {1'b0, dt_reg};
            end
        endcase

        div_start = cmd.op inside {OP_DIV_G1, OP_DIV_G2, OP_DIV_U};
        case (cmd.op)
            OP_DIV_G1:
            begin
                div_hi  = {80'd0, gm_second_reg[63:16]};
                div_lo  = {gm_second_reg[15:0], 48'd0};
                div_den = s_reg;
            end
            OP_DIV_G2:
            begin
                div_hi  = {80'd0, gm_first_reg[63:16]};
                div_lo  = {gm_first_reg[15:0], 48'd0};
                div_den = s_reg;
            end
            default:
            begin
                div_hi  = {66'd0, d_mag[63:2]};
                div_lo  = {d_mag[1:0], 62'd0};
                div_den = {64'd0, r_reg};
            end
        endcase
    end

    always_comb
    begin
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        dt2_next    = dt2_reg;
        tmp_next    = tmp_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        g1_next     = g1_reg;
        g2_next     = g2_reg;
        u_next      = u_reg;
        out_next    = out_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        case (cmd.op)
            OP_LOAD:
            begin
                pos_next[0] = in_word.load_x_first;
                pos_next[1] = in_word.load_y_first;
                pos_next[2] = in_word.load_x_second;
                pos_next[3] = in_word.load_y_second;
                vel_next[0] = in_word.load_vx_first;
                vel_next[1] = in_word.load_vy_first;
                vel_next[2] = in_word.load_vx_second;
                vel_next[3] = in_word.load_vy_second;
                halted_next = 1'b0;
            end
            OP_WB_DT2: dt2_next = qround(prod, 1'b0, 1'b0);
            OP_WB_V:   vel_next[cmd.k] = sat_add(vel_sel, qround(prod, 1'b0, acc_sel[63]));
            OP_WB_T:   tmp_next = sat_add(pos_sel, qround(prod, 1'b0, vel_sel[63]));
            OP_WB_P:   pos_next[cmd.k] = sat_sub(tmp_reg, qround(prod, 1'b1, acc_sel[63]));
            OP_SEP:
            begin
                dx_next = sat_sub(pos_reg[2], pos_reg[0]);
                dy_next = sat_sub(pos_reg[3], pos_reg[1]);
            end
            OP_WB_SX:  s_next = prod;
            OP_WB_SY:  s_next = s_reg + prod;
            OP_WB_CC:  if (s_reg < prod) halted_next = 1'b1;
            OP_ZERO_ACC:
            begin
                acc_next[0] = '0;
                acc_next[1] = '0;
                acc_next[2] = '0;
                acc_next[3] = '0;
            end
            OP_WB_R:   r_next = root;
            OP_WB_G1:  g1_next = (quo > G_CAP) ? G_CAP : quo;
            OP_WB_G2:  g2_next = (quo > G_CAP) ? G_CAP : quo;
            OP_WB_U:   u_next = quo;
            OP_WB_A1:  acc_next[cmd.k] = from_mag(d_sel[63], amag(prod));
            OP_WB_A2:  acc_next[k_hi] = from_mag(!d_sel[63], amag(prod));
            OP_OUT:
            begin
                out_next.pos_x_first  = pos_reg[0];
                out_next.pos_y_first  = pos_reg[1];
                out_next.pos_x_second = pos_reg[2];
                out_next.pos_y_second = pos_reg[3];
                out_next.collided     = halted_reg;
                out_valid_next        = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm_first_reg  <= GM_FIRST_RST;
            gm_second_reg <= GM_SECOND_RST;
            contact_reg   <= CONTACT_DIST_RST;
            dt_reg        <= TIME_STEP_RST;
            for (int i = 0; i < 4; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_GM_FIRST)
                    gm_first_reg <= cfg_data;
                if (cfg_index == CFG_GM_SECOND)
                    gm_second_reg <= cfg_data;
                if (cfg_index == CFG_CONTACT_DIST)
                    contact_reg <= cfg_data[62:0];
                if (cfg_index == CFG_TIME_STEP)
                    dt_reg <= cfg_data[62:0];
            end
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            acc_reg       <= acc_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt2_reg <= dt2_next;
        tmp_reg <= tmp_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        g1_reg  <= g1_next;
        g2_reg  <= g2_next;
        u_reg   <= u_next;
        out_reg <= out_next;
    end

    assign status.busy     = mul_busy | div_busy | sqrt_busy;
    assign status.s_zero   = s_reg == '0;
    assign status.halted   = halted_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_word        = out_reg;

endmodule

### rtl/core/two_body_gravity_step_core.sv
// ----------------------------------------------------------------------------
// two_body_gravity_step_core: planar two-body gravity stepper
// Loads or advances two bodies in signed Q32.32 and returns their positions
// with a sticky collision flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | in_word_t: cmd, load positions, velocities
//  out     | output    | out_valid/out_stall| out_word_t: four positions, collided
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A step after a collision goes straight to the output. The shared 64x64
//  multiplier (20 products per step, 6 per load) and the one-bit-per-cycle
//  square root and divider (four divides per step) do the arithmetic. One
//  word is in flight at a time; the next word is taken while the previous
//  result waits in the output register.
//  Reset clears the bodies, the collision flag and loads default configuration.
// ----------------------------------------------------------------------------
module two_body_gravity_step_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  tbgs_pkg::in_word_t               in_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output tbgs_pkg::out_word_t              out_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data
);
    import tbgs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tbgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_word.cmd),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    tbgs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### rtl/core/tbgs_checker.sv
// ----------------------------------------------------------------------------
// tbgs_checker: port-level checks for the gravity stepper
// Watches handshakes and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module tbgs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input tbgs_pkg::out_word_t out_word
);
    import tbgs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("output word dropped without accept");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after accept");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

endmodule

bind two_body_gravity_step_core tbgs_checker u_tbgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
